@@ design/lz10_pkg.sv @@
// Package for the LZ77 type 0x10 stream decoder.
// Holds the transfer payload types and the fixed stream constants.
// No dependencies.
package lz10_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } lz10_in_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  out_byte;
        logic [16:0] consumed_len;
        logic [1:0]  error_code;
        logic        out_last;
    } lz10_out_t;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_HEADER = 2'd1;
    localparam logic [1:0] ERR_SIZE   = 2'd2;
    localparam logic [1:0] ERR_TRUNC  = 2'd3;

    localparam logic [7:0]  HEADER_BYTE    = 8'h10;
    localparam logic [16:0] CONSUMED_MAX   = 17'h1FFFF;
    localparam logic [4:0]  MIN_MATCH      = 5'd3;
    localparam logic [3:0]  FLAGS_PER_BYTE = 4'd8;

endpackage

@@ design/lz77_type10_stream_decoder.sv @@
// Top level of the LZ77 type 0x10 stream decoder: header check, token
// sequencer and back-reference copy engine. Depends on lz10_pkg and lz10_ram.
//
//  channel  | signals                                   | payload
//  ---------+-------------------------------------------+------------
//  stream   | stream_valid, stream_stall, stream_data   | lz10_in_t
//  result   | result_valid, result_stall, result_data   | lz10_out_t
//
// Header, size, flag and match-low bytes are each taken as they arrive. A
// literal is accepted as a token byte and then emitted. A back-reference of
// 3 to 18 bytes is copied byte by byte after its second byte, through the
// single read and single write port of the history RAM; done or error is last.
// Reset is asynchronous and needs no clearing pass over the window.
// A stalled result holds the output states; stream_stall is high while they work.
module lz77_type10_stream_decoder
    import lz10_pkg::*;
#(
    parameter int MAX_OUT_LEN  = 65536,
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      stream_valid,
    output logic      stream_stall,
    input  lz10_in_t  stream_data,
    output logic      result_valid,
    input  logic      result_stall,
    output lz10_out_t result_data
);

    localparam int AW     = $clog2(WINDOW_DEPTH);
    localparam int DISP_W = AW + 1;
    localparam int WC_W   = $clog2(MAX_OUT_LEN + 1);
    localparam logic [23:0] MAX_LEN = 24'(MAX_OUT_LEN);

    localparam logic [2:0] ST_HEADER = 3'd0;
    localparam logic [2:0] ST_SIZE   = 3'd1;
    localparam logic [2:0] ST_TOKEN  = 3'd2;
    localparam logic [2:0] ST_MATCH  = 3'd3;
    localparam logic [2:0] ST_LIT    = 3'd4;
    localparam logic [2:0] ST_COPY   = 3'd5;
    localparam logic [2:0] ST_END    = 3'd6;
    localparam logic [2:0] ST_HALT   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        seen_reg, seen_next;
    logic [23:0]       target_reg, target_next;
    logic [WC_W-1:0]   wc_reg, wc_next;
    logic [16:0]       cons_reg, cons_next;
    logic [7:0]        flags_reg, flags_next;
    logic [3:0]        idx_reg, idx_next;
    logic [7:0]        high_reg, high_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [DISP_W-1:0] disp_reg, disp_next;
    logic [1:0]        err_reg, err_next;
    logic              last_reg, last_next;
    logic              out_valid_reg, out_valid_next;
    lz10_out_t         out_reg, out_next;
    logic [7:0]        byte_reg, byte_next;
    logic [7:0]        last_byte_reg, last_byte_next;

    logic              accepting;
    logic              in_fire;
    logic              out_free;
    logic              load;
    logic              we;
    logic [7:0]        wdata;
    logic [WC_W-1:0]   wc_inc;
    logic [WC_W-1:0]   rd_base;
    logic [DISP_W-1:0] rd_disp;
    logic [DISP_W-1:0] disp_in;
    logic [WC_W-1:0]   rd_diff;
    logic [23:0]       full_size;
    logic [7:0]        copy_val;
    logic [7:0]        ram_q;
    logic              reached;

    lz10_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk     (clk),
        .wr_en   (we),
        .wr_addr (wc_reg[AW-1:0]),
        .wr_data (wdata),
        .rd_addr (rd_diff[AW-1:0]),
        .rd_data (ram_q)
    );

    assign accepting = (state_reg == ST_HEADER) || (state_reg == ST_SIZE)
                    || (state_reg == ST_TOKEN) || (state_reg == ST_MATCH)
                    || (state_reg == ST_HALT);
    assign stream_stall = !accepting;
    assign in_fire      = stream_valid && accepting;
    assign out_free     = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    assign wc_inc    = wc_reg + 1'b1;
    assign disp_in   = DISP_W'({high_reg[3:0], stream_data.in_byte}) + 1'b1;
    assign full_size = {stream_data.in_byte, target_reg[15:0]};
    assign rd_diff   = rd_base - WC_W'(rd_disp);
    assign reached   = 24'(wc_inc) >= target_reg;

    // A distance of one reads the most recently written byte, which the
    // RAM may not return yet, so it comes from the bypass register.
    assign copy_val = (WC_W'(disp_reg) > wc_reg) ? 8'd0
                    : ((disp_reg == DISP_W'(1)) ? last_byte_reg : ram_q);

    always_comb
    begin
        state_next     = state_reg;
        seen_next      = seen_reg;
        target_next    = target_reg;
        wc_next        = wc_reg;
        cons_next      = cons_reg;
        flags_next     = flags_reg;
        idx_next       = idx_reg;
        high_next      = high_reg;
        cnt_next       = cnt_reg;
        disp_next      = disp_reg;
        err_next       = err_reg;
        last_next      = last_reg;
        byte_next      = byte_reg;
        last_byte_next = last_byte_reg;
        out_next       = out_reg;
        load           = 1'b0;
        we             = 1'b0;
        wdata          = byte_reg;
        rd_base        = wc_reg;
        rd_disp        = disp_reg;

        if (in_fire && (state_reg != ST_HALT))
        begin
            last_next = stream_data.is_last;
            if (cons_reg != CONSUMED_MAX)
            begin
                cons_next = cons_reg + 1'b1;
            end
        end

        case (state_reg)
            ST_HEADER:
            begin
                if (in_fire)
                begin
                    if ((stream_data.in_byte != HEADER_BYTE) || stream_data.is_last)
                    begin
                        err_next   = ERR_HEADER;
                        state_next = ST_END;
                    end
                    else
                    begin
                        state_next = ST_SIZE;
                    end
                end
            end
            ST_SIZE:
            begin
                if (in_fire)
                begin
                    seen_next = seen_reg + 1'b1;
                    case (seen_reg)
                        2'd0:    target_next[7:0]   = stream_data.in_byte;
                        2'd1:    target_next[15:8]  = stream_data.in_byte;
                        default: target_next[23:16] = stream_data.in_byte;
                    endcase
                    if (seen_reg != 2'd2)
                    begin
                        if (stream_data.is_last)
                        begin
                            err_next   = ERR_HEADER;
                            state_next = ST_END;
                        end
                    end
                    else if (full_size > MAX_LEN)
                    begin
                        err_next   = ERR_SIZE;
                        state_next = ST_END;
                    end
                    else if (full_size == 24'd0)
                    begin
                        err_next   = ERR_NONE;
                        state_next = ST_END;
                    end
                    else if (stream_data.is_last)
                    begin
                        err_next   = ERR_TRUNC;
                        state_next = ST_END;
                    end
                    else
                    begin
                        state_next = ST_TOKEN;
                    end
                end
            end
            ST_TOKEN:
            begin
                if (in_fire)
                begin
                    if (idx_reg >= FLAGS_PER_BYTE)
                    begin
                        flags_next = stream_data.in_byte;
                        idx_next   = 4'd0;
                        if (24'(wc_reg) >= target_reg)
                        begin
                            err_next   = ERR_NONE;
                            state_next = ST_END;
                        end
                        else if (stream_data.is_last)
                        begin
                            err_next   = ERR_TRUNC;
                            state_next = ST_END;
                        end
                    end
                    else if (flags_reg[7])
                    begin
                        high_next = stream_data.in_byte;
                        if (stream_data.is_last)
                        begin
                            err_next   = ERR_TRUNC;
                            state_next = ST_END;
                        end
                        else
                        begin
                            state_next = ST_MATCH;
                        end
                    end
                    else
                    begin
                        byte_next  = stream_data.in_byte;
                        state_next = ST_LIT;
                    end
                end
            end
            ST_MATCH:
            begin
                // The first window read is issued while the low byte transfers.
                rd_disp = disp_in;
                if (in_fire)
                begin
                    disp_next  = disp_in;
                    cnt_next   = 5'(high_reg[7:4]) + MIN_MATCH;
                    state_next = ST_COPY;
                end
            end
            ST_LIT:
            begin
                if (out_free)
                begin
                    load           = 1'b1;
                    we             = 1'b1;
                    wdata          = byte_reg;
                    last_byte_next = byte_reg;
                    wc_next        = wc_inc;
                    flags_next     = {flags_reg[6:0], 1'b0};
                    idx_next       = idx_reg + 1'b1;
                    out_next       = '0;
                    out_next.result_kind = KIND_DATA;
                    out_next.out_byte    = byte_reg;
                    if (reached)
                    begin
                        err_next   = ERR_NONE;
                        state_next = ST_END;
                    end
                    else if (last_reg)
                    begin
                        err_next   = ERR_TRUNC;
                        state_next = ST_END;
                    end
                    else
                    begin
                        out_next.out_last = 1'b1;
                        state_next        = ST_TOKEN;
                    end
                end
            end
            ST_COPY:
            begin
                if (out_free)
                begin
                    load           = 1'b1;
                    we             = 1'b1;
                    wdata          = copy_val;
                    last_byte_next = copy_val;
                    wc_next        = wc_inc;
                    cnt_next       = cnt_reg - 1'b1;
                    rd_base        = wc_inc;
                    out_next       = '0;
                    out_next.result_kind = KIND_DATA;
                    out_next.out_byte    = copy_val;
                    if ((cnt_reg == 5'd1) || reached)
                    begin
                        flags_next = {flags_reg[6:0], 1'b0};
                        idx_next   = idx_reg + 1'b1;
                        if (reached)
                        begin
                            err_next   = ERR_NONE;
                            state_next = ST_END;
                        end
                        else if (last_reg)
                        begin
                            err_next   = ERR_TRUNC;
                            state_next = ST_END;
                        end
                        else
                        begin
                            out_next.out_last = 1'b1;
                            state_next        = ST_TOKEN;
                        end
                    end
                end
            end
            ST_END:
            begin
                if (out_free)
                begin
                    load     = 1'b1;
                    out_next = '0;
                    out_next.error_code = err_reg;
                    out_next.out_last   = 1'b1;
                    if (err_reg == ERR_NONE)
                    begin
                        out_next.result_kind  = KIND_DONE;
                        out_next.consumed_len = cons_reg;
                    end
                    else
                    begin
                        out_next.result_kind = KIND_ERROR;
                    end
                    state_next = ST_HALT;
                end
            end
            ST_HALT:
            begin
                // Every later byte is taken and dropped until reset.
            end
            default:
            begin
                state_next = ST_HALT;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HEADER;
            seen_reg      <= 2'd0;
            target_reg    <= 24'd0;
            wc_reg        <= '0;
            cons_reg      <= 17'd0;
            flags_reg     <= 8'd0;
            idx_reg       <= FLAGS_PER_BYTE;
            high_reg      <= 8'd0;
            cnt_reg       <= 5'd0;
            disp_reg      <= '0;
            err_reg       <= ERR_NONE;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            target_reg    <= target_next;
            wc_reg        <= wc_next;
            cons_reg      <= cons_next;
            flags_reg     <= flags_next;
            idx_reg       <= idx_next;
            high_reg      <= high_next;
            cnt_reg       <= cnt_next;
            disp_reg      <= disp_next;
            err_reg       <= err_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg       <= out_next;
        byte_reg      <= byte_next;
        last_byte_reg <= last_byte_next;
    end

    // Once a done or error result is transferred, no result follows.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && (result_data.result_kind != KIND_DATA))
        |=> !result_valid)
        else $error("result offered after the end of the stream");

    // The output never runs past the declared size.
    assert property (@(posedge clk) disable iff (!rst_n)
        24'(wc_reg) <= target_reg)
        else $error("written count exceeds declared size");

    // A copy in progress always has bytes left to emit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY) |-> (cnt_reg != 5'd0))
        else $error("copy state with zero count");

    // An overwritten result would be lost.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_stall) |-> !load)
        else $error("result register loaded while stalled");

endmodule

@@ design/lz10_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the decoder's history window. No dependencies.
module lz10_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
